@@ sv/sgnb_pkg.sv @@
`default_nettype none
package sgnb_pkg;

  localparam int GRID_DIM_DEF   = 64;
  localparam int MAX_AGENTS_DEF = 64;

  localparam int CMD_W     = 3;
  localparam int AGENT_W   = 6;
  localparam int POS_W     = 24;
  localparam int RAD_W     = 20;
  localparam int INV_W     = 17;
  localparam int COUNT_W   = 7;
  localparam int FRAC_BITS = 16;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [1:0] REG_INV_CELL = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd2;

  // coordinate slots, even slots are x axis, odd slots are y axis
  localparam int NUM_COORDS  = 8;
  localparam int COORD_SEL_W = 3;
  localparam logic [COORD_SEL_W-1:0] SEL_POS_X = 3'd0;
  localparam logic [COORD_SEL_W-1:0] SEL_POS_Y = 3'd1;
  localparam logic [COORD_SEL_W-1:0] SEL_OLD_X = 3'd2;
  localparam logic [COORD_SEL_W-1:0] SEL_OLD_Y = 3'd3;
  localparam logic [COORD_SEL_W-1:0] SEL_QX0   = 3'd4;
  localparam logic [COORD_SEL_W-1:0] SEL_QY0   = 3'd5;
  localparam logic [COORD_SEL_W-1:0] SEL_QX1   = 3'd6;
  localparam logic [COORD_SEL_W-1:0] SEL_QY1   = 3'd7;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH       = 5'd1;
  localparam logic [OP_W-1:0] OP_SWEEP       = 5'd2;
  localparam logic [OP_W-1:0] OP_CLR_PRESENT = 5'd3;
  localparam logic [OP_W-1:0] OP_U_READ      = 5'd4;
  localparam logic [OP_W-1:0] OP_U_CELL      = 5'd5;
  localparam logic [OP_W-1:0] OP_U_WRITE     = 5'd6;
  localparam logic [OP_W-1:0] OP_A_READ      = 5'd7;
  localparam logic [OP_W-1:0] OP_A_WRITE     = 5'd8;
  localparam logic [OP_W-1:0] OP_A_LINK      = 5'd9;
  localparam logic [OP_W-1:0] OP_CNT_READ    = 5'd10;
  localparam logic [OP_W-1:0] OP_CNT_LATCH   = 5'd11;
  localparam logic [OP_W-1:0] OP_Q_START     = 5'd12;
  localparam logic [OP_W-1:0] OP_Q_CELL      = 5'd13;
  localparam logic [OP_W-1:0] OP_Q_HEAD      = 5'd14;
  localparam logic [OP_W-1:0] OP_Q_PUSH      = 5'd15;
  localparam logic [OP_W-1:0] OP_Q_NEXT      = 5'd16;
  localparam logic [OP_W-1:0] OP_FINISH      = 5'd17;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [AGENT_W-1:0]      agent;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] old_x;
    logic signed [POS_W-1:0] old_y;
    logic [RAD_W-1:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic [AGENT_W-1:0] neighbor_agent;
    logic               has_neighbor;
    logic [COUNT_W-1:0] cell_count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic                   coord_issue;
    logic [COORD_SEL_W-1:0] coord_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             coord_done;
    logic             agent_ok;
    logic             present_a;
    logic             keys_differ;
    logic             head_nil;
    logic             next_nil;
    logic             cell_last;
    logic             q_done;
    logic             can_push;
    logic             out_free;
    logic             sweep_last;
  } dp_status_t;

endpackage
`default_nettype wire

@@ sv/sgnb_coord.sv @@
`default_nettype none
module sgnb_coord #(
  parameter int GRID_DIM = sgnb_pkg::GRID_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue,
  input  logic [sgnb_pkg::COORD_SEL_W-1:0]    sel,
  input  sgnb_pkg::in_item_t                  item,
  input  logic [sgnb_pkg::INV_W-1:0]          inv_cell_size,
  input  logic [sgnb_pkg::POS_W-1:0]          origin_x,
  input  logic [sgnb_pkg::POS_W-1:0]          origin_y,
  output logic                                res_valid,
  output logic [sgnb_pkg::COORD_SEL_W-1:0]    res_idx,
  output logic [$clog2(GRID_DIM)-1:0]         res_coord
);
  import sgnb_pkg::*;

  localparam int CW  = $clog2(GRID_DIM);
  localparam int V_W = POS_W + 1;
  localparam int D_W = V_W + 1;
  localparam int P_W = D_W + INV_W + 1;
  localparam int F_W = P_W - FRAC_BITS;
  localparam logic signed [F_W-1:0] F_MAX = F_W'(GRID_DIM - 1);

  logic                   a_valid, b_valid, c_valid;
  logic [COORD_SEL_W-1:0] a_idx, b_idx, c_idx;
  logic [V_W-1:0]         v_sel, a_val;
  logic [V_W-1:0]         px_e, py_e, ox_e, oy_e, r_e;
  logic [D_W-1:0]         org_e;
  logic signed [D_W-1:0]  b_diff;
  logic signed [P_W-1:0]  c_prod;
  logic signed [F_W-1:0]  f;

  assign px_e = {item.pos_x[POS_W-1], item.pos_x};
  assign py_e = {item.pos_y[POS_W-1], item.pos_y};
  assign ox_e = {item.old_x[POS_W-1], item.old_x};
  assign oy_e = {item.old_y[POS_W-1], item.old_y};
  assign r_e  = V_W'(item.radius);

  always_comb begin
    case (sel)
      SEL_POS_X: v_sel = px_e;
      SEL_POS_Y: v_sel = py_e;
      SEL_OLD_X: v_sel = ox_e;
      SEL_OLD_Y: v_sel = oy_e;
      SEL_QX0:   v_sel = px_e - r_e;
      SEL_QY0:   v_sel = py_e - r_e;
      SEL_QX1:   v_sel = px_e + r_e;
      SEL_QY1:   v_sel = py_e + r_e;
      default:   v_sel = px_e;
    endcase
  end

  assign org_e = a_idx[0] ? {{2{origin_y[POS_W-1]}}, origin_y}
                          : {{2{origin_x[POS_W-1]}}, origin_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= issue;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_val  <= v_sel;
    a_idx  <= sel;
    b_diff <= {a_val[V_W-1], a_val} - org_e;
    b_idx  <= a_idx;
    c_prod <= b_diff * $signed({1'b0, inv_cell_size});
    c_idx  <= b_idx;
  end

  // arithmetic shift gives the floor, then clamp into the grid
  assign f = c_prod[P_W-1:FRAC_BITS];

  always_comb begin
    if (f[F_W-1]) begin
      res_coord = '0;
    end else if (f > F_MAX) begin
      res_coord = CW'(GRID_DIM - 1);
    end else begin
      res_coord = f[CW-1:0];
    end
  end

  assign res_valid = c_valid;
  assign res_idx   = c_idx;

endmodule
`default_nettype wire

@@ sv/sgnb_dp.sv @@
`default_nettype none
module sgnb_dp #(
  parameter int GRID_DIM   = sgnb_pkg::GRID_DIM_DEF,
  parameter int MAX_AGENTS = sgnb_pkg::MAX_AGENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sgnb_pkg::ctrl_cmd_t          cmd,
  output sgnb_pkg::dp_status_t         status,
  input  sgnb_pkg::in_item_t           in_item,
  input  logic [sgnb_pkg::INV_W-1:0]   inv_cell_size,
  input  logic [sgnb_pkg::POS_W-1:0]   origin_x,
  input  logic [sgnb_pkg::POS_W-1:0]   origin_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sgnb_pkg::out_item_t          out_item
);
  import sgnb_pkg::*;

  localparam int CW     = $clog2(GRID_DIM);
  localparam int NCELLS = GRID_DIM * GRID_DIM;
  localparam int KW     = $clog2(NCELLS);
  localparam int AW     = $clog2(MAX_AGENTS);
  localparam int LW     = $clog2(MAX_AGENTS + 1);
  localparam int CELL_W = 3 * LW;
  localparam logic [LW-1:0] NIL       = LW'(MAX_AGENTS);
  localparam logic [KW-1:0] GRID_K    = KW'(GRID_DIM);
  localparam logic [KW-1:0] LAST_CELL = KW'(NCELLS - 1);

  in_item_t item;
  logic [CW-1:0] coord [NUM_COORDS];
  logic [MAX_AGENTS-1:0] present;

  logic [KW-1:0]     key_mem  [MAX_AGENTS];
  logic [LW-1:0]     next_mem [MAX_AGENTS];
  logic [LW-1:0]     prev_mem [MAX_AGENTS];
  logic [CELL_W-1:0] cell_mem [NCELLS];

  logic [KW-1:0]     rd_key;
  logic [LW-1:0]     rd_next, rd_prev;
  logic [CELL_W-1:0] cell_rd;

  logic [LW-1:0] u_p, u_n, a_t, g;
  logic [KW-1:0] u_k, sweep_cnt;
  logic [CW-1:0] cx, cy;
  logic          q_done;
  logic [AW-1:0] pend;
  logic          pend_valid;
  logic [LW-1:0] res_count;

  logic                   res_valid;
  logic [COORD_SEL_W-1:0] res_idx;
  logic [CW-1:0]          res_coord;

  logic [AW-1:0] a_idx, agent_addr;
  logic [KW-1:0] key_new, key_old, qkey, cell_raddr, cell_waddr;
  logic [LW-1:0] cell_head, cell_tail, cell_pop;
  logic          cell_we, next_we, prev_we, key_we;
  logic [CELL_W-1:0] cell_wdata;
  logic [AW-1:0] next_waddr, prev_waddr;
  logic [LW-1:0] next_wdata, prev_wdata, new_head, new_tail, new_pop;
  logic          out_free, do_push, do_finish, cell_last;

  sgnb_coord #(.GRID_DIM(GRID_DIM)) u_coord (
    .clk           (clk),
    .rst           (rst),
    .issue         (cmd.coord_issue),
    .sel           (cmd.coord_sel),
    .item          (item),
    .inv_cell_size (inv_cell_size),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .res_valid     (res_valid),
    .res_idx       (res_idx),
    .res_coord     (res_coord)
  );

  assign a_idx   = item.agent[AW-1:0];
  assign key_new = KW'(coord[SEL_POS_Y]) * GRID_K + KW'(coord[SEL_POS_X]);
  assign key_old = KW'(coord[SEL_OLD_Y]) * GRID_K + KW'(coord[SEL_OLD_X]);
  assign qkey    = KW'(cy) * GRID_K + KW'(cx);

  assign cell_head = cell_rd[3*LW-1:2*LW];
  assign cell_tail = cell_rd[2*LW-1:LW];
  assign cell_pop  = cell_rd[LW-1:0];

  assign cell_last = (cx == coord[SEL_QX1]) && (cy == coord[SEL_QY1]);
  assign out_free  = !out_valid || out_ready;
  assign do_push   = (cmd.op == OP_Q_PUSH);
  assign do_finish = (cmd.op == OP_FINISH);

  assign agent_addr = (cmd.op == OP_Q_PUSH) ? g[AW-1:0] : a_idx;

  always_comb begin
    case (cmd.op)
      OP_U_CELL: cell_raddr = rd_key;
      OP_Q_CELL: cell_raddr = qkey;
      default:   cell_raddr = key_new;
    endcase
  end

  always_comb begin
    new_head   = (u_p != NIL) ? cell_head : u_n;
    new_tail   = (u_n != NIL) ? cell_tail : u_p;
    new_pop    = (cell_pop != '0) ? cell_pop - LW'(1) : cell_pop;
    cell_we    = 1'b0;
    cell_waddr = key_new;
    cell_wdata = {new_head, new_tail, new_pop};
    next_we    = 1'b0;
    next_waddr = a_idx;
    next_wdata = NIL;
    prev_we    = 1'b0;
    prev_waddr = a_idx;
    prev_wdata = cell_tail;
    key_we     = 1'b0;
    case (cmd.op)
      OP_SWEEP: begin
        cell_we    = 1'b1;
        cell_waddr = sweep_cnt;
        cell_wdata = {NIL, NIL, LW'(0)};
      end
      OP_U_WRITE: begin
        cell_we    = 1'b1;
        cell_waddr = u_k;
        next_we    = (u_p != NIL);
        next_waddr = u_p[AW-1:0];
        next_wdata = u_n;
        prev_we    = (u_n != NIL);
        prev_waddr = u_n[AW-1:0];
        prev_wdata = u_p;
      end
      OP_A_WRITE: begin
        cell_we    = 1'b1;
        cell_wdata = {(cell_tail != NIL) ? cell_head : LW'(a_idx), LW'(a_idx),
                      cell_pop + LW'(1)};
        next_we    = 1'b1;
        prev_we    = 1'b1;
        key_we     = 1'b1;
      end
      OP_A_LINK: begin
        // old tail of the cell now points at the new agent
        next_we    = (a_t != NIL);
        next_waddr = a_t[AW-1:0];
        next_wdata = LW'(a_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_rd <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    rd_next <= next_mem[agent_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    rd_prev <= prev_mem[agent_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[a_idx] <= key_new;
    rd_key <= key_mem[agent_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      sweep_cnt  <= '0;
    end else begin
      case (cmd.op)
        OP_CLR_PRESENT: present <= '0;
        OP_U_WRITE:     present[a_idx] <= 1'b0;
        OP_A_LINK:      present[a_idx] <= 1'b1;
        default: ;
      endcase
      if (cmd.op == OP_SWEEP) begin
        sweep_cnt <= (sweep_cnt == LAST_CELL) ? '0 : sweep_cnt + KW'(1);
      end
      if (cmd.op == OP_LATCH || do_finish) begin
        pend_valid <= 1'b0;
      end else if (do_push) begin
        pend_valid <= 1'b1;
      end
      if ((do_push && pend_valid) || do_finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) coord[res_idx] <= res_coord;
    case (cmd.op)
      OP_LATCH: begin
        item      <= in_item;
        res_count <= '0;
      end
      OP_CNT_LATCH: res_count <= cell_pop;
      OP_U_CELL: begin
        u_p <= rd_prev;
        u_n <= rd_next;
        u_k <= rd_key;
      end
      OP_A_WRITE: a_t <= cell_tail;
      OP_Q_START: begin
        cx <= coord[SEL_QX0];
        cy <= coord[SEL_QY0];
      end
      OP_Q_HEAD: begin
        g      <= cell_head;
        q_done <= cell_last;
        if (cx == coord[SEL_QX1]) begin
          cx <= coord[SEL_QX0];
          cy <= cy + CW'(1);
        end else begin
          cx <= cx + CW'(1);
        end
      end
      OP_Q_NEXT: g <= rd_next;
      default: ;
    endcase
    // one agent is held back so the final one can carry last
    if (do_push) begin
      pend <= g[AW-1:0];
      if (pend_valid) begin
        out_item.neighbor_agent <= AGENT_W'(pend);
        out_item.has_neighbor   <= 1'b1;
        out_item.cell_count     <= '0;
        out_item.last           <= 1'b0;
      end
    end else if (do_finish) begin
      out_item.neighbor_agent <= pend_valid ? AGENT_W'(pend) : '0;
      out_item.has_neighbor   <= pend_valid;
      out_item.cell_count     <= pend_valid ? '0 : COUNT_W'(res_count);
      out_item.last           <= 1'b1;
    end
  end

  assign status.command     = item.command;
  assign status.coord_done  = res_valid && (res_idx == SEL_QY1);
  assign status.agent_ok    = ({1'b0, item.agent} < (AGENT_W + 1)'(MAX_AGENTS));
  assign status.present_a   = present[a_idx];
  assign status.keys_differ = (key_new != key_old);
  assign status.head_nil    = (cell_head == NIL);
  assign status.next_nil    = (rd_next == NIL);
  assign status.cell_last   = cell_last;
  assign status.q_done      = q_done;
  assign status.can_push    = !pend_valid || out_free;
  assign status.out_free    = out_free;
  assign status.sweep_last  = (sweep_cnt == LAST_CELL);

endmodule
`default_nettype wire

@@ sv/sgnb_ctrl.sv @@
`default_nettype none
module sgnb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sgnb_pkg::dp_status_t status,
  output sgnb_pkg::ctrl_cmd_t  cmd
);
  import sgnb_pkg::*;

  localparam int CNT_W = $clog2(NUM_COORDS + 1);

  localparam logic [4:0] S_SWEEP     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_COORD     = 5'd2;
  localparam logic [4:0] S_DISPATCH  = 5'd3;
  localparam logic [4:0] S_U_READ    = 5'd4;
  localparam logic [4:0] S_U_CELL    = 5'd5;
  localparam logic [4:0] S_U_WRITE   = 5'd6;
  localparam logic [4:0] S_A_READ    = 5'd7;
  localparam logic [4:0] S_A_WRITE   = 5'd8;
  localparam logic [4:0] S_A_LINK    = 5'd9;
  localparam logic [4:0] S_CNT_READ  = 5'd10;
  localparam logic [4:0] S_CNT_LATCH = 5'd11;
  localparam logic [4:0] S_Q_CELL    = 5'd12;
  localparam logic [4:0] S_Q_HEAD    = 5'd13;
  localparam logic [4:0] S_Q_WALK    = 5'd14;
  localparam logic [4:0] S_Q_NEXT    = 5'd15;
  localparam logic [4:0] S_FINISH    = 5'd16;

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] coord_cnt, coord_cnt_next;
  logic             do_append, do_append_next;
  logic             sweep_fin, sweep_fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      coord_cnt <= '0;
      do_append <= 1'b0;
      sweep_fin <= 1'b0;
    end else begin
      state     <= state_next;
      coord_cnt <= coord_cnt_next;
      do_append <= do_append_next;
      sweep_fin <= sweep_fin_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    coord_cnt_next = coord_cnt;
    do_append_next = do_append;
    sweep_fin_next = sweep_fin;
    cmd            = '0;
    cmd.op         = OP_NONE;
    case (state)
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (status.sweep_last) state_next = sweep_fin ? S_FINISH : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op         = OP_LATCH;
          coord_cnt_next = '0;
          state_next     = S_COORD;
        end
      end
      S_COORD: begin
        if (coord_cnt != CNT_W'(NUM_COORDS)) begin
          cmd.coord_issue = 1'b1;
          cmd.coord_sel   = coord_cnt[COORD_SEL_W-1:0];
          coord_cnt_next  = coord_cnt + CNT_W'(1);
        end
        if (status.coord_done) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (status.command)
          CMD_INSERT: begin
            do_append_next = 1'b1;
            if (!status.agent_ok) state_next = S_FINISH;
            else state_next = status.present_a ? S_U_READ : S_A_READ;
          end
          CMD_REMOVE: begin
            do_append_next = 1'b0;
            state_next = (status.agent_ok && status.present_a) ? S_U_READ : S_FINISH;
          end
          CMD_MOVE: begin
            do_append_next = 1'b1;
            if (!(status.agent_ok && status.keys_differ)) state_next = S_FINISH;
            else state_next = status.present_a ? S_U_READ : S_A_READ;
          end
          CMD_QUERY: begin
            cmd.op     = OP_Q_START;
            state_next = S_Q_CELL;
          end
          CMD_COUNT: state_next = S_CNT_READ;
          CMD_CLEAR: begin
            cmd.op         = OP_CLR_PRESENT;
            sweep_fin_next = 1'b1;
            state_next     = S_SWEEP;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_U_READ: begin
        cmd.op     = OP_U_READ;
        state_next = S_U_CELL;
      end
      S_U_CELL: begin
        cmd.op     = OP_U_CELL;
        state_next = S_U_WRITE;
      end
      S_U_WRITE: begin
        cmd.op     = OP_U_WRITE;
        state_next = do_append ? S_A_READ : S_FINISH;
      end
      S_A_READ: begin
        cmd.op     = OP_A_READ;
        state_next = S_A_WRITE;
      end
      S_A_WRITE: begin
        cmd.op     = OP_A_WRITE;
        state_next = S_A_LINK;
      end
      S_A_LINK: begin
        cmd.op     = OP_A_LINK;
        state_next = S_FINISH;
      end
      S_CNT_READ: begin
        cmd.op     = OP_CNT_READ;
        state_next = S_CNT_LATCH;
      end
      S_CNT_LATCH: begin
        cmd.op     = OP_CNT_LATCH;
        state_next = S_FINISH;
      end
      S_Q_CELL: begin
        cmd.op     = OP_Q_CELL;
        state_next = S_Q_HEAD;
      end
      S_Q_HEAD: begin
        cmd.op = OP_Q_HEAD;
        if (!status.head_nil) state_next = S_Q_WALK;
        else state_next = status.cell_last ? S_FINISH : S_Q_CELL;
      end
      S_Q_WALK: begin
        if (status.can_push) begin
          cmd.op     = OP_Q_PUSH;
          state_next = S_Q_NEXT;
        end
      end
      S_Q_NEXT: begin
        cmd.op = OP_Q_NEXT;
        if (!status.next_nil) state_next = S_Q_WALK;
        else state_next = status.q_done ? S_FINISH : S_Q_CELL;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.op         = OP_FINISH;
          sweep_fin_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/spatial_grid_neighbor_binning_top.sv @@
// one transaction at a time: an accept step, mapping of its positions to cells and a dispatch
// step; then insert/remove/move unlink and/or append the agent, count reads the cell, and a
// query walks each scanned cell and each agent found in it before a final result
// results leave through an output register, so the next transaction is taken while one waits
// reset (synchronous, active high) starts a clearing pass over all GRID_DIM*GRID_DIM
// cells (4096 by default) with input held off; a clear command runs the same pass
`default_nettype none
module spatial_grid_neighbor_binning_top #(
  parameter int GRID_DIM   = sgnb_pkg::GRID_DIM_DEF,
  parameter int MAX_AGENTS = sgnb_pkg::MAX_AGENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sgnb_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sgnb_pkg::out_item_t             out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sgnb_pkg::PADDR_W-1:0]    paddr,
  input  logic [sgnb_pkg::PDATA_W-1:0]    pwdata,
  output logic [sgnb_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import sgnb_pkg::*;

  logic [INV_W-1:0] inv_cell_size;
  logic [POS_W-1:0] origin_x, origin_y;
  logic [1:0]       reg_idx;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_size <= INV_W'(65536);
      origin_x      <= '0;
      origin_y      <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_INV_CELL: inv_cell_size <= pwdata[INV_W-1:0];
        REG_ORIGIN_X: origin_x      <= pwdata[POS_W-1:0];
        REG_ORIGIN_Y: origin_y      <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INV_CELL: prdata = PDATA_W'(inv_cell_size);
      REG_ORIGIN_X: prdata = {{(PDATA_W - POS_W){origin_x[POS_W-1]}}, origin_x};
      REG_ORIGIN_Y: prdata = {{(PDATA_W - POS_W){origin_y[POS_W-1]}}, origin_y};
      default:      prdata = '0;
    endcase
  end

  sgnb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sgnb_dp #(
    .GRID_DIM   (GRID_DIM),
    .MAX_AGENTS (MAX_AGENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_item       (in_item),
    .inv_cell_size (inv_cell_size),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

endmodule
`default_nettype wire

@@ tb/spatial_grid_neighbor_binning_top_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spatial_grid_neighbor_binning_top_tb;
  import sgnb_pkg::*;

  localparam int GRID = 64;
  localparam int AGENTS = 64;
  localparam int NIL = 64;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  spatial_grid_neighbor_binning_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // grid model state
  logic [16:0] m_inv;
  longint m_org_x, m_org_y;
  bit m_present[AGENTS];
  int m_key[AGENTS];
  int m_next[AGENTS];
  int m_prev[AGENTS];
  int m_head[GRID*GRID];
  int m_tail[GRID*GRID];
  int m_pop[GRID*GRID];

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int queries_run = 0;
  bit send_idle_ok = 1'b1;
  bit recv_idle_ok = 1'b1;
  bit hold_send = 1'b0;
  // accept flag sampled on the rising edge, consumed by the driver at the falling edge
  bit in_ready_seen = 1'b0;

  function automatic int cell_coord(longint p, longint org);
    longint prod, f;
    prod = (p - org) * longint'(m_inv);
    if (prod >= 0) f = prod / 65536;
    else f = -((-prod + 65535) / 65536);
    if (f < 0) f = 0;
    if (f > GRID - 1) f = GRID - 1;
    return int'(f);
  endfunction

  function automatic int cell_key(longint x, longint y);
    return cell_coord(y, m_org_y) * GRID + cell_coord(x, m_org_x);
  endfunction

  function automatic void grid_clear();
    for (int i = 0; i < AGENTS; i++) m_present[i] = 1'b0;
    for (int i = 0; i < GRID*GRID; i++) begin
      m_head[i] = NIL;
      m_tail[i] = NIL;
      m_pop[i] = 0;
    end
  endfunction

  function automatic void grid_unlink(int a);
    int k, p, n;
    if (!m_present[a]) return;
    k = m_key[a];
    p = m_prev[a];
    n = m_next[a];
    if (p < AGENTS) m_next[p] = n;
    else m_head[k] = n;
    if (n < AGENTS) m_prev[n] = p;
    else m_tail[k] = p;
    if (m_pop[k] > 0) m_pop[k]--;
    m_present[a] = 1'b0;
  endfunction

  function automatic void grid_append(int a, int k);
    int t;
    t = m_tail[k];
    m_prev[a] = t;
    m_next[a] = NIL;
    if (t < AGENTS) m_next[t] = a;
    else m_head[k] = a;
    m_tail[k] = a;
    m_pop[k]++;
    m_key[a] = k;
    m_present[a] = 1'b1;
  endfunction

  function automatic void apply_command(in_item_t it);
    out_item_t r;
    longint px, py, rad;
    int a, cnt, x0, x1, y0, y1, g, guard;
    px = longint'(it.pos_x);
    py = longint'(it.pos_y);
    rad = longint'(it.radius);
    a = int'(it.agent);
    r = '0;
    r.last = 1'b1;
    case (it.command)
      CMD_INSERT: begin
        grid_unlink(a);
        grid_append(a, cell_key(px, py));
      end
      CMD_REMOVE: grid_unlink(a);
      CMD_MOVE: begin
        if (cell_key(longint'(it.old_x), longint'(it.old_y)) != cell_key(px, py)) begin
          grid_unlink(a);
          grid_append(a, cell_key(px, py));
        end
      end
      CMD_QUERY: begin
        cnt = 0;
        queries_run++;
        x0 = cell_coord(px - rad, m_org_x);
        x1 = cell_coord(px + rad, m_org_x);
        y0 = cell_coord(py - rad, m_org_y);
        y1 = cell_coord(py + rad, m_org_y);
        for (int cy = y0; cy <= y1; cy++) begin
          for (int cx = x0; cx <= x1; cx++) begin
            g = m_head[cy*GRID + cx];
            guard = 0;
            while (g < AGENTS && cnt < AGENTS && guard < AGENTS) begin
              r = '0;
              r.neighbor_agent = g[5:0];
              r.has_neighbor = 1'b1;
              expected_results.push_back(r);
              cnt++;
              guard++;
              g = m_next[g];
            end
          end
        end
        if (cnt > 0) begin
          r = expected_results.pop_back();
          r.last = 1'b1;
        end
      end
      CMD_COUNT: r.cell_count = m_pop[cell_key(px, py)][6:0];
      CMD_CLEAR: grid_clear();
      default: ;
    endcase
    expected_results.push_back(r);
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_items.size() > 0 && !hold_send &&
            !(send_idle_ok && $urandom_range(99) < 18)) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !(recv_idle_ok && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_ready_seen <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) apply_command(in_item);
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_item);
        errors <= errors + 1;
      end else begin
        out_item_t want;
        want = expected_results.pop_front();
        if (want !== out_item) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, want, out_item);
          errors <= errors + 1;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_INV_CELL: m_inv = val[16:0];
      REG_ORIGIN_X: m_org_x = longint'($signed(val[23:0]));
      default: m_org_y = longint'($signed(val[23:0]));
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    // a clear finishes its sweep before its result is sent
    repeat (4200) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [2:0] c, int a, int x, int y, int r);
    in_item_t it;
    it.command = c;
    it.agent = a[5:0];
    it.pos_x = x[23:0];
    it.pos_y = y[23:0];
    it.old_x = POS_W'($urandom);
    it.old_y = POS_W'($urandom);
    it.radius = r[19:0];
    return it;
  endfunction

  // positions mostly near the grid so cells fill up
  function automatic int near_pos(longint org, logic [16:0] inv);
    longint span;
    span = (inv == 0) ? 64 : (64 * 65536) / inv + 2;
    if ($urandom_range(9) == 0) return $urandom;
    return int'(org + longint'($urandom_range(int'(span))) - 1);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it = make_item(CMD_INSERT, $urandom_range(63), near_pos(m_org_x, m_inv),
                   near_pos(m_org_y, m_inv), 0);
    if (sel < 35) it.command = CMD_INSERT;
    else if (sel < 47) it.command = CMD_REMOVE;
    else if (sel < 62) begin
      it.command = CMD_MOVE;
      if ($urandom_range(3) == 0) begin
        it.old_x = it.pos_x;
        it.old_y = it.pos_y;
      end else begin
        it.old_x = POS_W'(near_pos(m_org_x, m_inv));
        it.old_y = POS_W'(near_pos(m_org_y, m_inv));
      end
    end else if (sel < 85) begin
      it.command = CMD_QUERY;
      it.radius = ($urandom_range(19) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(3));
    end else if (sel < 96) it.command = CMD_COUNT;
    else if (sel < 97) it.command = CMD_CLEAR;
    else it.command = 3'd6 + CMD_W'($urandom_range(1));
    return it;
  endfunction

  initial begin
    in_item_t it;
    m_inv = 17'd65536;
    m_org_x = 0;
    m_org_y = 0;
    grid_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corners, every command, edge cases
    pending_items.push_back(make_item(CMD_INSERT, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_INSERT, 63, 8388607, 8388607, 0));
    pending_items.push_back(make_item(CMD_INSERT, 5, -8388608, -8388608, 0));
    pending_items.push_back(make_item(CMD_INSERT, 7, 1, 0, 0));
    pending_items.push_back(make_item(CMD_INSERT, 0, 1, 0, 0));
    pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 1048575));
    pending_items.push_back(make_item(CMD_QUERY, 0, 40, 40, 0));
    pending_items.push_back(make_item(CMD_COUNT, 0, 1, 0, 0));
    pending_items.push_back(make_item(CMD_COUNT, 0, 100, 100, 0));
    it = make_item(CMD_MOVE, 7, 1, 0, 0);
    it.old_x = 1;
    it.old_y = 0;
    pending_items.push_back(it);
    it = make_item(CMD_MOVE, 9, 3, 3, 0);
    it.old_x = 0;
    it.old_y = 0;
    pending_items.push_back(it);
    pending_items.push_back(make_item(CMD_REMOVE, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_REMOVE, 0, 0, 0, 0));
    pending_items.push_back(make_item(3'd6, 1, 0, 0, 0));
    pending_items.push_back(make_item(3'd7, 1, 0, 0, 0));
    pending_items.push_back(make_item(CMD_QUERY, 0, 2, 2, 3));
    pending_items.push_back(make_item(CMD_CLEAR, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_QUERY, 0, 0, 0, 1048575));
    wait_drained();

    // register settings including extremes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          reg_write(REG_INV_CELL, 32'd1);
          reg_write(REG_ORIGIN_X, 32'h800000);
          reg_write(REG_ORIGIN_Y, 32'h7FFFFF);
        end
        1: begin
          reg_write(REG_INV_CELL, 32'd16384);
          reg_write(REG_ORIGIN_X, -32'sd100);
          reg_write(REG_ORIGIN_Y, 32'd50);
        end
        2: begin
          reg_write(REG_INV_CELL, 32'd0);
          reg_write(REG_ORIGIN_X, 32'd0);
          reg_write(REG_ORIGIN_Y, 32'd0);
        end
        3: begin
          reg_write(REG_INV_CELL, 32'h1FFFF);
          reg_write(REG_ORIGIN_X, 32'd7);
          reg_write(REG_ORIGIN_Y, -32'sd3);
          recv_idle_ok = 1'b0;
          send_idle_ok = 1'b0;
        end
        4: begin
          reg_write(REG_INV_CELL, 32'd65536);
          reg_write(REG_ORIGIN_X, $urandom);
          reg_write(REG_ORIGIN_Y, $urandom);
          recv_idle_ok = 1'b1;
          send_idle_ok = 1'b1;
        end
        default: begin
          reg_write(REG_INV_CELL, 32'd32768);
          reg_write(REG_ORIGIN_X, 32'd0);
          reg_write(REG_ORIGIN_Y, 32'd0);
        end
      endcase
      for (int n = 0; n < 70; n++) pending_items.push_back(random_item());
      if (phase == 1) begin
        // let everything drain before more traffic
        while (pending_items.size() > 35) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d results, %0d queries across 7 register settings",
             results_seen, queries_run);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/sgnb_pkg.sv
sv/sgnb_coord.sv
sv/sgnb_dp.sv
sv/sgnb_ctrl.sv
sv/spatial_grid_neighbor_binning_top.sv
tb/spatial_grid_neighbor_binning_top_tb.sv
